FILE: design/tct_pkg.sv
// Shared types, constants and helper functions for the three-channel target timer.
`default_nettype none

package tct_pkg;

   localparam int NumTimers      = 3;
   localparam int CntW           = 16;
   localparam int BatchW         = 8;
   localparam int ModeW          = 10;
   localparam int CsrIdxW        = 3;
   localparam int CsrDataW       = 16;
   localparam int IrqW           = NumTimers;
   localparam int MaxBatchCycles = 255;

   // mode register bit positions
   localparam int ModeSyncEn   = 0;
   localparam int ModeSyncLo   = 1;
   localparam int ModeRstTgt   = 3;
   localparam int ModeIrqLo    = 4;
   localparam int ModeRepeat   = 6;
   localparam int ModeToggle   = 7;
   localparam int ModeClkSelLo = 8;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MODE0   = 3'd0,
      CSR_MODE1   = 3'd1,
      CSR_MODE2   = 3'd2,
      CSR_TARGET0 = 3'd3,
      CSR_TARGET1 = 3'd4,
      CSR_TARGET2 = 3'd5
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // only these four status bits can ever be set
   typedef struct packed {
      logic ffff_hit;
      logic target_hit;
      logic toggle;
      logic oneshot_done;
   } flags_type;

   typedef struct packed {
      logic [CntW-1:0] count;
      flags_type       flags;
      logic            irq;
   } step_result_type;

   function automatic logic [CntW-1:0] expand_status(input flags_type f);
      logic [CntW-1:0] w;
      w     = '0;
      w[2]  = f.oneshot_done;
      w[10] = f.toggle;
      w[12] = f.target_hit;
      w[13] = f.ffff_hit;
      return w;
   endfunction

   // increments for one item from clock source and sync gating
   function automatic logic [BatchW-1:0] pick_increment(
      input logic [1:0]        idx,
      input logic [ModeW-1:0]  mode,
      input logic [BatchW-1:0] batch,
      input logic              hbl,
      input logic              vbl
   );
      logic [1:0]        csel;
      logic [1:0]        sm;
      logic              lvl;
      logic [BatchW-1:0] inc;
      csel = mode[ModeClkSelLo +: 2];
      sm   = mode[ModeSyncLo +: 2];
      lvl  = (idx == 2'd0) ? hbl : vbl;
      if (idx != 2'd2) begin
         inc = csel[0] ? '0 : batch;
      end else begin
         inc = csel[1] ? (batch >> 3) : batch;
      end
      if (mode[ModeSyncEn]) begin
         if (idx != 2'd2) begin
            if ((sm == 2'd2) && !lvl) inc = '0;
            if ((sm == 2'd0) && lvl)  inc = '0;
         end else if ((sm == 2'd0) || (sm == 2'd3)) begin
            inc = '0;
         end
      end
      return inc;
   endfunction

   // one counter tick with target/overflow handling
   function automatic step_result_type timer_step(
      input logic [CntW-1:0]  cnt,
      input flags_type        flags,
      input logic [ModeW-1:0] mode,
      input logic [CntW-1:0]  target
   );
      step_result_type r;
      logic [CntW:0]   nxt;
      logic [CntW:0]   cmp;
      logic            hit_t;
      logic            hit_f;
      nxt   = {1'b0, cnt} + (CntW+1)'(1);
      cmp   = (target == '0) ? {1'b1, {CntW{1'b0}}} : {1'b0, target};
      hit_t = mode[ModeRstTgt] && (nxt >= cmp);
      hit_f = !mode[ModeRstTgt] && nxt[CntW];
      r.flags = flags;
      r.irq   = 1'b0;
      if (hit_t || hit_f) begin
         r.count            = '0;
         r.flags.target_hit = hit_t;
         r.flags.ffff_hit   = !hit_t;
         if ((mode[ModeIrqLo +: 2] != 2'b00) && !flags.oneshot_done) begin
            r.irq = 1'b1;
            if (mode[ModeToggle]) r.flags.toggle = !flags.toggle;
            if (!mode[ModeRepeat]) r.flags.oneshot_done = 1'b1;
         end
      end else begin
         r.count = nxt[CntW-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/tct_ifs.sv
// Handshake interfaces for the request, response and register write channels.
`default_nettype none

interface tct_req_if import tct_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BatchW-1:0] cycle_batch;
   logic              hblank_level;
   logic              vblank_level;
   modport source (output valid, output cycle_batch, output hblank_level,
                   output vblank_level, input ready);
   modport sink   (input valid, input cycle_batch, input hblank_level,
                   input vblank_level, output ready);
endinterface

interface tct_rsp_if import tct_pkg::*;;
   logic            valid;
   logic            ready;
   logic [IrqW-1:0] irq_raised;
   logic [CntW-1:0] count0_value;
   logic [CntW-1:0] count1_value;
   logic [CntW-1:0] count2_value;
   logic [CntW-1:0] status0_word;
   logic [CntW-1:0] status1_word;
   logic [CntW-1:0] status2_word;
   modport source (output valid, output irq_raised, output count0_value,
                   output count1_value, output count2_value, output status0_word,
                   output status1_word, output status2_word, input ready);
   modport sink   (input valid, input irq_raised, input count0_value,
                   input count1_value, input count2_value, input status0_word,
                   input status1_word, input status2_word, output ready);
endinterface

interface tct_csr_if import tct_pkg::*;;
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/three_channel_target_timer.sv
// Three 16-bit counter/timers with target compare, status flags and interrupt reporting.
// Each request beat carries a batch of elapsed system cycles and the blanking levels.
// After the beat is taken the block picks an increment count per timer and then ticks
// the counters one cycle at a time under a step counter, all three timers in lockstep;
// a timer stops ticking once its own count is used up. When the largest increment of
// the three timers (0 to 255) is used up, the response register is loaded, the
// response beat goes valid and the block returns to idle, where the next request beat
// can be taken. The request side is not ready while the block is busy. If the previous
// response beat is still stalled when the ticks are done, the block waits until it is
// taken. The response beat sits in an output register, so the next request can be taken
// while it waits. Register writes are taken every cycle and belong to idle periods.
`default_nettype none

module three_channel_target_timer import tct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tct_req_if.sink     req,
   tct_rsp_if.source   rsp,
   tct_csr_if.sink     csr
);

   logic [ModeW-1:0]  mode_ff   [NumTimers];
   logic [CntW-1:0]   target_ff [NumTimers];
   logic [CntW-1:0]   count_ff  [NumTimers];
   logic [CntW-1:0]   count_in  [NumTimers];
   flags_type         flags_ff  [NumTimers];
   flags_type         flags_in  [NumTimers];
   logic [BatchW-1:0] inc_ff    [NumTimers];
   logic [BatchW-1:0] inc_in    [NumTimers];
   step_result_type   step_res  [NumTimers];
   logic [NumTimers-1:0] active;

   state_type         state_ff, state_in;
   logic [BatchW-1:0] step_ff, step_in;
   logic [IrqW-1:0]   irq_ff, irq_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_load;
   logic [IrqW-1:0]   rsp_irq_ff;
   logic [CntW-1:0]   rsp_count_ff  [NumTimers];
   logic [CntW-1:0]   rsp_status_ff [NumTimers];

   logic [BatchW-1:0] batch_sat;

   assign csr.ready = 1'b1;

   // register writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumTimers; i++) begin
            mode_ff[i]   <= '0;
            target_ff[i] <= '0;
         end
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_MODE0:   mode_ff[0]   <= csr.data[ModeW-1:0];
            CSR_MODE1:   mode_ff[1]   <= csr.data[ModeW-1:0];
            CSR_MODE2:   mode_ff[2]   <= csr.data[ModeW-1:0];
            CSR_TARGET0: target_ff[0] <= csr.data[CntW-1:0];
            CSR_TARGET1: target_ff[1] <= csr.data[CntW-1:0];
            CSR_TARGET2: target_ff[2] <= csr.data[CntW-1:0];
            default: ;
         endcase
      end
   end

   assign batch_sat = (32'(req.cycle_batch) > MaxBatchCycles) ?
                      BatchW'(MaxBatchCycles) : req.cycle_batch;

   // per-timer tick units
   always_comb begin
      for (int i = 0; i < NumTimers; i++) begin
         active[i]   = step_ff < inc_ff[i];
         step_res[i] = timer_step(count_ff[i], flags_ff[i], mode_ff[i], target_ff[i]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      irq_in       = irq_ff;
      rsp_load     = 1'b0;
      req.ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      for (int i = 0; i < NumTimers; i++) begin
         inc_in[i]   = inc_ff[i];
         count_in[i] = count_ff[i];
         flags_in[i] = flags_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               for (int i = 0; i < NumTimers; i++) begin
                  inc_in[i] = pick_increment(2'(i), mode_ff[i], batch_sat,
                                             req.hblank_level, req.vblank_level);
               end
               step_in  = '0;
               irq_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (|active) begin
               for (int i = 0; i < NumTimers; i++) begin
                  if (active[i]) begin
                     count_in[i] = step_res[i].count;
                     flags_in[i] = step_res[i].flags;
                     irq_in[i]   = irq_ff[i] | step_res[i].irq;
                  end
               end
               step_in = step_ff + BatchW'(1);
            end else if (!rsp_valid_ff || rsp.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NumTimers; i++) begin
            count_ff[i] <= '0;
            flags_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NumTimers; i++) begin
            count_ff[i] <= count_in[i];
            flags_ff[i] <= flags_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      irq_ff  <= irq_in;
      for (int i = 0; i < NumTimers; i++) begin
         inc_ff[i] <= inc_in[i];
      end
      if (rsp_load) begin
         rsp_irq_ff <= irq_ff;
         for (int i = 0; i < NumTimers; i++) begin
            rsp_count_ff[i]  <= count_ff[i];
            rsp_status_ff[i] <= expand_status(flags_ff[i]);
         end
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.irq_raised   = rsp_irq_ff;
   assign rsp.count0_value = rsp_count_ff[0];
   assign rsp.count1_value = rsp_count_ff[1];
   assign rsp.count2_value = rsp_count_ff[2];
   assign rsp.status0_word = rsp_status_ff[0];
   assign rsp.status1_word = rsp_status_ff[1];
   assign rsp.status2_word = rsp_status_ff[2];

endmodule

`default_nettype wire

FILE: design/tct_checker.sv
// Port-level checks for the three-channel target timer, bound to the top level.
`default_nettype none

module tct_checker import tct_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [IrqW-1:0] rsp_irq_raised,
   input logic [CntW-1:0] rsp_count0_value,
   input logic [CntW-1:0] rsp_status0_word
);

   // response beat must hold while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_irq_raised)
         && $stable(rsp_count0_value) && $stable(rsp_status0_word))
      else $error("response beat changed while stalled");

   // block goes busy right after taking a request beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request side still ready after a beat was taken");

   // a new response only appears at the end of a busy period
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without an item in flight");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind three_channel_target_timer tct_checker u_tct_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_irq_raised   (rsp.irq_raised),
   .rsp_count0_value (rsp.count0_value),
   .rsp_status0_word (rsp.status0_word)
);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the three-channel target timer: directed and random batches.
`default_nettype none

module tb import tct_pkg::*;;

   // status word bit positions
   localparam int StOneShot = 2;
   localparam int StToggle  = 10;
   localparam int StTarget  = 12;
   localparam int StFfff    = 13;

   // mode register fields, as written through the csr port
   localparam logic [CsrDataW-1:0] MSync    = CsrDataW'(1 << ModeSyncEn);
   localparam logic [CsrDataW-1:0] MRstTgt  = CsrDataW'(1 << ModeRstTgt);
   localparam logic [CsrDataW-1:0] MIrqA    = CsrDataW'(1 << ModeIrqLo);
   localparam logic [CsrDataW-1:0] MIrqB    = CsrDataW'(2 << ModeIrqLo);
   localparam logic [CsrDataW-1:0] MRepeat  = CsrDataW'(1 << ModeRepeat);
   localparam logic [CsrDataW-1:0] MToggle  = CsrDataW'(1 << ModeToggle);

   localparam int HoldCycles = 800;
   localparam int PhaseItems = 140;

   typedef struct packed {
      logic [IrqW-1:0]                irq;
      logic [NumTimers-1:0][CntW-1:0] count;
      logic [NumTimers-1:0][CntW-1:0] status;
   } timer_readout_type;

   logic clock = 1'b0;
   logic reset;

   tct_req_if req_ch ();
   tct_rsp_if rsp_ch ();
   tct_csr_if csr_ch ();

   three_channel_target_timer DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // predictor state
   logic [ModeW-1:0] mode_shadow   [NumTimers];
   logic [CntW-1:0]  target_shadow [NumTimers];
   logic [CntW-1:0]  count_model   [NumTimers];
   logic [CntW-1:0]  status_model  [NumTimers];

   timer_readout_type expected_readouts [$];
   timer_readout_type want_now;

   int error_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_len      = 0;
   int hold_left     = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #8000000;
      $display("TEST FAILED");
      $finish;
   end

   // ticks a timer gets from one batch: clock source first, then blanking gate
   function automatic int unsigned ticks_for(input int t, input logic [ModeW-1:0] m,
                                             input int unsigned cyc, input logic hbl,
                                             input logic vbl);
      logic [1:0]  clk_src;
      logic [1:0]  sync_sel;
      logic        gate_lvl;
      int unsigned n;
      clk_src  = m[ModeClkSelLo +: 2];
      sync_sel = m[ModeSyncLo +: 2];
      gate_lvl = (t == 0) ? hbl : vbl;
      if (t < 2) begin
         n = (clk_src == 2'd1 || clk_src == 2'd3) ? 0 : cyc;
      end else begin
         n = (clk_src >= 2'd2) ? cyc / 8 : cyc;
      end
      if (m[ModeSyncEn]) begin
         if (t < 2) begin
            if (sync_sel == 2'd2 && !gate_lvl) n = 0;
            if (sync_sel == 2'd0 && gate_lvl) n = 0;
         end else if (sync_sel == 2'd0 || sync_sel == 2'd3) begin
            n = 0;
         end
      end
      return n;
   endfunction

   function automatic timer_readout_type advance_timers(input int unsigned cyc,
                                                        input logic hbl, input logic vbl);
      timer_readout_type snap;
      int unsigned    n;
      int unsigned    limit;
      int unsigned    nxt;
      int unsigned    k;
      logic           rst_tgt;
      int             t;
      snap = '0;
      if (cyc > MaxBatchCycles) cyc = MaxBatchCycles;
      for (t = 0; t < NumTimers; t++) begin
         n       = ticks_for(t, mode_shadow[t], cyc, hbl, vbl);
         limit   = (target_shadow[t] == '0) ? 32'h10000 : 32'(target_shadow[t]);
         rst_tgt = mode_shadow[t][ModeRstTgt];
         for (k = 0; k < n; k++) begin
            nxt = count_model[t] + 1;
            if ((rst_tgt && nxt >= limit) || (!rst_tgt && nxt >= 32'h10000)) begin
               count_model[t]            = '0;
               status_model[t][StTarget] = rst_tgt;
               status_model[t][StFfff]   = !rst_tgt;
               if (mode_shadow[t][ModeIrqLo +: 2] != 2'b00 && !status_model[t][StOneShot]) begin
                  snap.irq[t] = 1'b1;
                  if (mode_shadow[t][ModeToggle])
                     status_model[t][StToggle] = !status_model[t][StToggle];
                  if (!mode_shadow[t][ModeRepeat]) status_model[t][StOneShot] = 1'b1;
               end
            end else begin
               count_model[t] = nxt[CntW-1:0];
            end
         end
         snap.count[t]  = count_model[t];
         snap.status[t] = status_model[t];
      end
      return snap;
   endfunction

   // valid stays up across back-to-back beats; only lowered when the sender idles
   task automatic send_batch(input logic [BatchW-1:0] cyc, input logic hbl, input logic vbl);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cycle_batch  <= cyc;
      req_ch.hblank_level <= hbl;
      req_ch.vblank_level <= vbl;
      do @(posedge clock); while (!req_ch.ready);
      expected_readouts.push_back(advance_timers(cyc, hbl, vbl));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_readouts.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_MODE0:   mode_shadow[0]   = data[ModeW-1:0];
         CSR_MODE1:   mode_shadow[1]   = data[ModeW-1:0];
         CSR_MODE2:   mode_shadow[2]   = data[ModeW-1:0];
         CSR_TARGET0: target_shadow[0] = data;
         CSR_TARGET1: target_shadow[1] = data;
         CSR_TARGET2: target_shadow[2] = data;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic configure_timer(input int t, input logic [CsrDataW-1:0] mode,
                                  input logic [CsrDataW-1:0] tgt);
      case (t)
         0: begin
            write_csr(CSR_MODE0, mode);
            write_csr(CSR_TARGET0, tgt);
         end
         1: begin
            write_csr(CSR_MODE1, mode);
            write_csr(CSR_TARGET1, tgt);
         end
         default: begin
            write_csr(CSR_MODE2, mode);
            write_csr(CSR_TARGET2, tgt);
         end
      endcase
   endtask

   function automatic logic [CsrDataW-1:0] pick_target();
      case ($urandom_range(0, 5))
         0:       return '0;
         1, 2:    return CsrDataW'($urandom_range(1, 400));
         3:       return '1;
         default: return CsrDataW'($urandom);
      endcase
   endfunction

   function automatic logic [BatchW-1:0] pick_batch();
      case ($urandom_range(0, 9))
         0, 1:    return BatchW'($urandom_range(0, 15));
         2:       return BatchW'($urandom_range(240, 255));
         default: return BatchW'($urandom);
      endcase
   endfunction

   // one-shot done is sticky until reset, so keep repeat set unless asked
   task automatic randomize_timers(input bit allow_oneshot);
      logic [CsrDataW-1:0] m;
      int                  t;
      for (t = 0; t < NumTimers; t++) begin
         m = CsrDataW'($urandom);
         if (!allow_oneshot) m[ModeRepeat] = 1'b1;
         configure_timer(t, m, pick_target());
      end
   endtask

   task automatic check_field(input string name, input logic [CntW-1:0] want,
                              input logic [CntW-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      end
   endtask

   // receiver: random stalls, plus a long hold-off when a test asks for one
   always @(negedge clock) begin
      if (hold_len != 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_readouts.size() == 0) begin
            error_count++;
            $display("%0t response beat with nothing expected", $time);
         end else begin
            want_now = expected_readouts.pop_front();
            check_field("irq_raised",   CntW'(want_now.irq), CntW'(rsp_ch.irq_raised));
            check_field("count0_value", want_now.count[0],   rsp_ch.count0_value);
            check_field("count1_value", want_now.count[1],   rsp_ch.count1_value);
            check_field("count2_value", want_now.count[2],   rsp_ch.count2_value);
            check_field("status0_word", want_now.status[0],  rsp_ch.status0_word);
            check_field("status1_word", want_now.status[1],  rsp_ch.status1_word);
            check_field("status2_word", want_now.status[2],  rsp_ch.status2_word);
         end
      end
   end

   task automatic test_reset_values();
      send_batch(8'd0, 1'b0, 1'b0);
      send_batch(8'd255, 1'b1, 1'b1);
      send_batch(8'd1, 1'b0, 1'b1);
      drain_results();
   endtask

   task automatic test_sync_gating();
      configure_timer(0, MSync | CsrDataW'(2 << ModeSyncLo), '0);
      configure_timer(1, MSync, '0);
      configure_timer(2, MSync, '0);
      send_batch(8'd40, 1'b0, 1'b0);
      send_batch(8'd40, 1'b1, 1'b0);
      send_batch(8'd40, 1'b0, 1'b1);
      send_batch(8'd40, 1'b1, 1'b1);
      drain_results();
      configure_timer(0, MSync, '0);
      configure_timer(1, MSync | CsrDataW'(2 << ModeSyncLo), '0);
      configure_timer(2, MSync | CsrDataW'(3 << ModeSyncLo), '0);
      send_batch(8'd40, 1'b1, 1'b1);
      send_batch(8'd40, 1'b0, 1'b0);
      drain_results();
      // sync modes that do not gate
      configure_timer(0, MSync | CsrDataW'(1 << ModeSyncLo), '0);
      configure_timer(1, MSync | CsrDataW'(3 << ModeSyncLo), '0);
      configure_timer(2, MSync | CsrDataW'(2 << ModeSyncLo), '0);
      send_batch(8'd30, 1'b1, 1'b0);
      drain_results();
   endtask

   task automatic test_clock_select();
      configure_timer(0, CsrDataW'(1 << ModeClkSelLo), '0);
      configure_timer(1, CsrDataW'(3 << ModeClkSelLo), '0);
      configure_timer(2, CsrDataW'(2 << ModeClkSelLo), '0);
      send_batch(8'd255, 1'b0, 1'b0);
      send_batch(8'd7, 1'b1, 1'b1);   // divided source truncates to zero
      drain_results();
      configure_timer(0, CsrDataW'(3 << ModeClkSelLo), '0);
      configure_timer(1, CsrDataW'(2 << ModeClkSelLo), '0);
      configure_timer(2, CsrDataW'(3 << ModeClkSelLo), '0);
      send_batch(8'd17, 1'b0, 1'b0);
      drain_results();
      configure_timer(0, CsrDataW'(2 << ModeClkSelLo), '0);
      configure_timer(1, CsrDataW'(1 << ModeClkSelLo), '0);
      configure_timer(2, CsrDataW'(1 << ModeClkSelLo), '0);
      send_batch(8'd100, 1'b1, 1'b0);
      drain_results();
   endtask

   task automatic test_target_hits();
      configure_timer(0, '0, '0);
      configure_timer(1, '0, '0);
      configure_timer(2, '0, '0);
      send_batch(8'd255, 1'b0, 1'b0);
      send_batch(8'd255, 1'b0, 1'b0);
      drain_results();
      // counters 0 and 1 now sit above their new targets; timer 0's first tick is a hit
      configure_timer(0, MRstTgt | MIrqA | MRepeat | MToggle, 16'd10);
      configure_timer(1, 16'hFC00 | MRstTgt | MIrqB | MRepeat, 16'd1);
      configure_timer(2, MRstTgt | MIrqA | MIrqB | MRepeat | MToggle, 16'h0000);
      send_batch(8'd1, 1'b0, 1'b0);
      send_batch(8'd255, 1'b1, 1'b0);
      send_batch(8'd0, 1'b0, 1'b1);
      drain_results();
   endtask

   task automatic test_rollover();
      int i;
      configure_timer(0, MIrqA | MIrqB | MRepeat | MToggle, 16'h1234);
      configure_timer(1, MIrqA | MRepeat, 16'h0000);
      configure_timer(2, MRstTgt | MIrqB | MRepeat | MToggle, 16'h0000);
      for (i = 0; i < 290; i++)
         send_batch(BatchW'($urandom_range(224, 255)), 1'($urandom), 1'($urandom));
      drain_results();
   endtask

   task automatic test_backpressure();
      int i;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure_timer(0, MRstTgt | MIrqA | MRepeat | MToggle, 16'd37);
      configure_timer(1, MRstTgt | MIrqB | MRepeat, 16'd200);
      configure_timer(2, MIrqA | MRepeat, 16'd5);
      hold_len = HoldCycles;
      for (i = 0; i < 10; i++) send_batch(pick_batch(), 1'($urandom), 1'($urandom));
      // sender waits for every beat to come back before going on
      drain_results();
      for (i = 0; i < 6; i++) send_batch(pick_batch(), 1'($urandom), 1'($urandom));
      drain_results();
   endtask

   task automatic test_random_traffic();
      int s;
      int p;
      int i;
      for (s = 0; s < 3; s++) begin
         case (s)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 83;
            end
            1: begin
               send_idle_pct = 83;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (p = 0; p < 4; p++) begin
            drain_results();
            if (s == 0 && p == 0) begin
               for (i = 0; i < NumTimers; i++) configure_timer(i, '1, '1);
            end else if (s == 1 && p == 0) begin
               for (i = 0; i < NumTimers; i++) configure_timer(i, '0, '0);
            end else begin
               randomize_timers(s == 2 && p == 3);
            end
            for (i = 0; i < PhaseItems; i++)
               send_batch(pick_batch(), 1'($urandom), 1'($urandom));
         end
      end
      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
   endtask

   task automatic test_one_shot();
      configure_timer(0, MRstTgt | MIrqA | MToggle, 16'd3);
      configure_timer(1, MRstTgt, 16'd2);
      configure_timer(2, MRstTgt | MIrqA | MIrqB, 16'h00FF);
      send_batch(8'd255, 1'b0, 1'b0);
      send_batch(8'd255, 1'b0, 1'b0);
      send_batch(8'd9, 1'b1, 1'b1);
      drain_results();
   endtask

   initial begin
      int t;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.cycle_batch  = '0;
      req_ch.hblank_level = 1'b0;
      req_ch.vblank_level = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_MODE0;
      csr_ch.data         = '0;
      for (t = 0; t < NumTimers; t++) begin
         mode_shadow[t]   = '0;
         target_shadow[t] = '0;
         count_model[t]   = '0;
         status_model[t]  = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_sync_gating();
      test_clock_select();
      test_target_hits();
      test_rollover();
      test_backpressure();
      test_random_traffic();
      test_one_shot();

      drain_results();
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
